// ===== sv/dft_pkg.sv =====
// Package for the decayed frequency tracker: item structs, codes and the record layout.
// No dependencies.
package dft_pkg;

  localparam int unsigned SLOTS = 256;

  localparam logic [1:0] ACT_ADMIT    = 2'd0;
  localparam logic [1:0] ACT_CREDIT   = 2'd1;
  localparam logic [1:0] ACT_QUOTE    = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam logic [1:0] CLS_UNAVAIL = 2'd0;
  localparam logic [1:0] CLS_TRACK   = 2'd1;
  localparam logic [1:0] CLS_PROMO   = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_COALESCED = 2'd1;
  localparam logic [1:0] ST_UNAVAIL   = 2'd2;
  localparam logic [1:0] ST_REJECT    = 2'd3;

  localparam logic [1:0] REG_CREDIT = 2'd0;
  localparam logic [1:0] REG_SMAX   = 2'd1;
  localparam logic [1:0] REG_DECAY  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam int unsigned PRIOR_DIV = 1000;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slot;
    logic [31:0] epoch;
    logic [9:0]  prior_permille;
    logic        start_unavailable;
    logic [31:0] avoided_work;
    logic [31:0] marginal_cost;
    logic [31:0] recency_rank;
  } dft_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  frequency_class;
    logic [31:0] score_now;
    logic [31:0] hits_now;
    logic [63:0] lost_value;
  } dft_out_t;

  // One table record, stored as one memory word
  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] score;
    logic [31:0] hits;
    logic [31:0] adm;
    logic [31:0] cur;
    logic [31:0] lc;
    logic [9:0]  prior;
  } dft_rec_t;

endpackage

// ===== sv/dft_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/dft_div.sv =====
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
// No dependencies.
module dft_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        busy_q, busy_d, done_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (go_i) begin
      busy_d = 1'b1; cnt_d = 6'd0; rem_d = '0; quo_d = num_i; den_d = den_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign quo_o = quo_q;
endmodule

// ===== sv/decayed_frequency_tracker.sv =====
// Top level of the decayed frequency tracker: record table, sequencer, divider.
// Depends on dft_pkg, dft_ram and dft_div.
//
// Usage: pulse start with an item while busy is low. An admit, or a reject of the
// action, slot or quote operands, ends in S_READ; a record check that rejects the
// item or finds it unavailable ends in S_CHECK; a credit runs on through S_DIV1 and
// S_CRED, and a quote through S_DIV1, S_CRED, S_DIV2, S_MUL and S_OUT. The long paths
// are set by the bit-serial 32-bit divider (one pass for credit, two for quote) and
// by the quote sum and 64 by 32 multiply, done in 16-bit steps across S_MUL and
// S_OUT. The result is shown for one cycle with done_o high, the first cycle with
// busy low, and cannot be held off. The occupancy bits reset at once, so no clearing
// pass is needed.
module decayed_frequency_tracker #(
  parameter logic [31:0] SCORE_ONE = 32'd65536,
  parameter int unsigned PRIOR_MAX = 1000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dft_pkg::dft_in_t  item_i,
  output logic              done_o,
  output dft_pkg::dft_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import dft_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RW = $bits(dft_rec_t);

  // Prior scaling split into a whole part and a remainder part per thousandth
  localparam logic [31:0] PQ_WHOLE = 32'(SCORE_ONE / PRIOR_DIV);
  localparam logic [9:0]  PQ_FRAC  = 10'(SCORE_ONE % PRIOR_DIV);
  localparam logic [20:0] PQ_RECIP = 21'(((64'd1 << 30) + PRIOR_DIV - 1) / PRIOR_DIV);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_DIV1, S_CRED, S_DIV2, S_MUL, S_OUT
  } state_e;

  state_e   state_q;
  dft_in_t  in_q;
  dft_rec_t rec_q, rd_rec, wr_rec;
  logic [31:0] cred_q, smax_q, dint_q, thr_q;
  logic [SLOTS-1:0] used_q;
  logic [AW-1:0] addr, rd_addr;
  logic        we;
  logic [31:0] sh1_q, sc_q;
  logic [63:0] pq_q, sig_q;
  logic [95:0] acc_q;
  logic [1:0]  mcnt_q;
  logic        div_go, div_done;
  logic [31:0] div_num, div_quo;
  logic [RW-1:0] rd_raw;

  assign addr = in_q.slot[AW-1:0];
  // Read the incoming slot while idle so the record is ready in S_READ
  assign rd_addr = busy ? addr : item_i.slot[AW-1:0];
  assign rd_rec = dft_rec_t'(rd_raw);
  assign busy = (state_q != S_IDLE);

  dft_ram #(.Width(RW), .Depth(SLOTS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(addr), .wdata_i(wr_rec),
    .raddr_i(rd_addr), .rdata_o(rd_raw)
  );

  dft_div u_div (
    .clk_i, .rst_ni, .go_i(div_go), .num_i(div_num), .den_i(dint_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= 32'd65536; smax_q <= '1; dint_q <= 32'd1; thr_q <= 32'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CREDIT: cred_q <= cfg_data_i;
        REG_SMAX:   smax_q <= cfg_data_i;
        REG_DECAY:  dint_q <= cfg_data_i;
        REG_THRESH: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Record and config consistency
  logic cfg_ok, rec_ok, slot_ok;
  always_comb begin
    cfg_ok = cred_q != 0 && smax_q >= cred_q && dint_q != 0 && thr_q >= 32'd2;
    rec_ok = !(rec_q.cls > CLS_PROMO || rec_q.prior == 0 || 32'(rec_q.prior) > PRIOR_MAX ||
               rec_q.adm == 0 || rec_q.adm > in_q.epoch || rec_q.cur < rec_q.adm ||
               rec_q.cur > in_q.epoch || (rec_q.lc != 0 && rec_q.lc < rec_q.adm) ||
               rec_q.lc > in_q.epoch || ((rec_q.hits == 0) != (rec_q.lc == 0)));
    if (rec_q.cls == CLS_UNAVAIL)
      rec_ok = rec_ok && rec_q.hits == 0 && rec_q.score == 0 && rec_q.lc == 0;
    else if (rec_q.cls == CLS_PROMO)
      rec_ok = rec_ok && rec_q.hits >= 32'd2;
    slot_ok = 32'(in_q.slot) < SLOTS;
  end

  // Write data per state
  logic [31:0] dec_sc, new_sc, new_hits;
  logic [63:0] raw_prior;
  logic [19:0] frac_num;
  logic [40:0] frac_prod;
  logic [41:0] whole_prod;
  always_comb begin
    dec_sc = (sh1_q >= 32) ? 32'd0 : (rec_q.score >> sh1_q[4:0]);
    new_sc = (dec_sc > smax_q - cred_q) ? smax_q : dec_sc + cred_q;
    new_hits = (rec_q.hits == '1) ? rec_q.hits : rec_q.hits + 32'd1;
    // SCORE_ONE * prior / 1000; reciprocal multiply is exact for remainder * prior < 2^20
    frac_num = 20'(PQ_FRAC) * 20'(rec_q.prior);
    frac_prod = 41'(frac_num) * 41'(PQ_RECIP);
    whole_prod = 42'(PQ_WHOLE) * 42'(rec_q.prior);
    raw_prior = 64'(whole_prod) + 64'(frac_prod[40:30]);
    wr_rec = rec_q;
    we = 1'b0;
    div_go = 1'b0;
    div_num = in_q.epoch - rec_q.cur;
    if (state_q == S_READ && in_q.action == ACT_ADMIT) begin
      we = slot_ok && in_q.epoch != 0 && in_q.prior_permille != 0 &&
           32'(in_q.prior_permille) <= PRIOR_MAX;
      wr_rec.cls = in_q.start_unavailable ? CLS_UNAVAIL : CLS_TRACK;
      wr_rec.score = '0; wr_rec.hits = '0; wr_rec.adm = in_q.epoch;
      wr_rec.cur = in_q.epoch; wr_rec.lc = '0; wr_rec.prior = in_q.prior_permille;
    end
    if (state_q == S_CHECK && rec_q.cls == CLS_UNAVAIL && in_q.action == ACT_CREDIT &&
        used_q[addr] && cfg_ok && rec_ok) begin
      we = 1'b1; wr_rec.cur = in_q.epoch;
    end
    // Only a credit writes back; a quote leaves the table alone
    if (state_q == S_CRED) begin
      we = (in_q.action == ACT_CREDIT);
      wr_rec.cur = rec_q.cur + sh1_q * dint_q;
      if (rec_q.lc == in_q.epoch) wr_rec.score = dec_sc;
      else begin
        wr_rec.score = new_sc; wr_rec.hits = new_hits; wr_rec.lc = in_q.epoch;
        if (new_hits >= thr_q) wr_rec.cls = CLS_PROMO;
      end
    end
    if (state_q == S_CHECK) div_go = 1'b1;
    if (state_q == S_CRED && in_q.action == ACT_QUOTE) begin
      div_go = 1'b1; div_num = in_q.epoch - rec_q.adm;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; done_o <= 1'b0;
    end else begin
      if (we && state_q == S_READ) used_q[addr] <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          done_o <= 1'b0;
          if (start) state_q <= S_READ;
        end
        S_READ: begin
          if (!slot_ok || in_q.action == ACT_RESERVED || in_q.action == ACT_ADMIT) begin
            state_q <= S_IDLE; done_o <= 1'b1;
          end else if (in_q.action == ACT_QUOTE &&
                       (in_q.marginal_cost == 0 || in_q.recency_rank == 0)) begin
            state_q <= S_IDLE; done_o <= 1'b1;
          end else state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!used_q[addr] || !cfg_ok || !rec_ok || rec_q.cls == CLS_UNAVAIL) begin
            state_q <= S_IDLE; done_o <= 1'b1;
          end else state_q <= S_DIV1;
        end
        S_DIV1: if (div_done) state_q <= S_CRED;
        S_CRED: begin
          if (in_q.action == ACT_CREDIT) begin
            state_q <= S_IDLE; done_o <= 1'b1;
          end else state_q <= S_DIV2;
        end
        S_DIV2: if (div_done) state_q <= S_MUL;
        S_MUL: if (mcnt_q == 2'd3) state_q <= S_OUT;
        S_OUT: begin state_q <= S_IDLE; done_o <= 1'b1; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        in_q <= item_i;
        mcnt_q <= '0;
      end
      S_READ: begin
        rec_q <= rd_rec;
        if (we)
          result_o <= '{status: ST_DONE, frequency_class: wr_rec.cls,
                        score_now: '0, hits_now: '0, lost_value: '0};
        else
          result_o <= '{status: ST_REJECT, frequency_class: 2'd0, score_now: '0,
                        hits_now: '0, lost_value: '0};
      end
      S_CHECK: begin
        if (used_q[addr] && cfg_ok && rec_ok && rec_q.cls == CLS_UNAVAIL)
          result_o.status <= ST_UNAVAIL;
      end
      S_DIV1: sh1_q <= div_quo;
      S_CRED: begin
        sc_q <= dec_sc;
        if (rec_q.lc == in_q.epoch)
          result_o <= '{status: ST_COALESCED, frequency_class: rec_q.cls,
                        score_now: dec_sc, hits_now: rec_q.hits, lost_value: '0};
        else
          result_o <= '{status: ST_DONE, frequency_class: wr_rec.cls,
                        score_now: new_sc, hits_now: new_hits, lost_value: '0};
      end
      S_DIV2: begin
        pq_q <= (div_quo >= 64) ? 64'd0 : (raw_prior >> div_quo[5:0]);
        sig_q <= '0;
        acc_q <= '0;
      end
      S_MUL: begin
        mcnt_q <= mcnt_q + 2'd1;
        // 64x32 product in 16-bit partial steps of the multiplicand
        if (mcnt_q == 2'd0) sig_q <= {32'd0, sc_q} + pq_q;
        else acc_q <= acc_q + ((96'(sig_q[16*(mcnt_q-1) +: 16]) *
                      96'(in_q.avoided_work)) << (16*(mcnt_q-1)));
      end
      S_OUT: begin
        logic [95:0] full;
        full = acc_q + ((96'(sig_q[63:48]) * 96'(in_q.avoided_work)) << 48);
        if (full[95:64] != 0)
          result_o <= '{status: ST_REJECT, frequency_class: 2'd0, score_now: '0,
                        hits_now: '0, lost_value: '0};
        else
          result_o <= '{status: ST_DONE, frequency_class: rec_q.cls, score_now: sc_q,
                        hits_now: rec_q.hits, lost_value: full[63:0]};
      end
      default: ;
    endcase
  end
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for decayed_frequency_tracker: directed and random items.
// Depends on dft_pkg and the decayed_frequency_tracker RTL.
`timescale 1ns / 1ps

module tb_top;
  import dft_pkg::*;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  dft_in_t     item;
  logic        done;
  dft_out_t    result;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  decayed_frequency_tracker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .item_i     (item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow registers and record table
  logic [31:0] credit_amt, score_max, decay_ivl, promo_thresh;
  logic        used_q   [TABLE_SIZE];
  logic [1:0]  cls_q    [TABLE_SIZE];
  logic [31:0] score_q  [TABLE_SIZE];
  logic [31:0] hits_q   [TABLE_SIZE];
  logic [31:0] adm_q    [TABLE_SIZE];
  logic [31:0] cursor_q [TABLE_SIZE];
  logic [31:0] credit_ep_q [TABLE_SIZE];
  logic [9:0]  prior_q  [TABLE_SIZE];

  dft_out_t    pending_results[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned idle_pct;
  logic [31:0] epoch_now;

  function automatic dft_out_t reject_result();
    dft_out_t r;
    r = '0;
    r.status = ST_REJECT;
    return r;
  endfunction

  function automatic logic [31:0] halve_by(logic [31:0] v, logic [31:0] n);
    return (n >= 32) ? 32'd0 : (v >> n);
  endfunction

  function automatic logic record_valid(int s, logic [31:0] now);
    if (cls_q[s] > CLS_PROMO || prior_q[s] == 0 || prior_q[s] > 10'd1000 ||
        adm_q[s] == 0 || adm_q[s] > now || cursor_q[s] < adm_q[s] || cursor_q[s] > now ||
        (credit_ep_q[s] != 0 && credit_ep_q[s] < adm_q[s]) || credit_ep_q[s] > now ||
        ((hits_q[s] == 0) != (credit_ep_q[s] == 0)))
      return 1'b0;
    if (cls_q[s] == CLS_UNAVAIL)
      return hits_q[s] == 0 && score_q[s] == 0 && credit_ep_q[s] == 0;
    return cls_q[s] != CLS_PROMO || hits_q[s] >= 2;
  endfunction

  // Expected result of one item; updates the shadow table
  function automatic dft_out_t track_item(dft_in_t it);
    dft_out_t    r;
    int          s;
    logic [31:0] now, steps, cur, sc;
    logic [63:0] raw, pq, sig;
    logic        cfg_ok;
    r = '0;
    s = it.slot;
    now = it.epoch;
    cfg_ok = credit_amt != 0 && score_max >= credit_amt && decay_ivl != 0 &&
             promo_thresh >= 2;
    if (it.action == ACT_RESERVED) return reject_result();
    if (it.action == ACT_ADMIT) begin
      if (now == 0 || it.prior_permille == 0 || it.prior_permille > 10'd1000)
        return reject_result();
      used_q[s] = 1'b1;
      cls_q[s] = it.start_unavailable ? CLS_UNAVAIL : CLS_TRACK;
      score_q[s] = '0;
      hits_q[s] = '0;
      adm_q[s] = now;
      cursor_q[s] = now;
      credit_ep_q[s] = '0;
      prior_q[s] = it.prior_permille;
      r.status = ST_DONE;
      r.frequency_class = cls_q[s];
      return r;
    end
    if (it.action == ACT_QUOTE && (it.marginal_cost == 0 || it.recency_rank == 0))
      return reject_result();
    if (!used_q[s] || !cfg_ok) return reject_result();
    if (!record_valid(s, now)) return reject_result();
    if (cls_q[s] == CLS_UNAVAIL) begin
      if (it.action == ACT_CREDIT) cursor_q[s] = now;
      r.status = ST_UNAVAIL;
      return r;
    end
    steps = (now - cursor_q[s]) / decay_ivl;
    cur = cursor_q[s] + steps * decay_ivl;
    sc = halve_by(score_q[s], steps);
    if (it.action == ACT_CREDIT) begin
      score_q[s] = sc;
      cursor_q[s] = cur;
      if (credit_ep_q[s] == now) begin
        r.status = ST_COALESCED;
      end else begin
        sc = (sc > score_max - credit_amt) ? score_max : sc + credit_amt;
        score_q[s] = sc;
        if (hits_q[s] != 32'hFFFF_FFFF) hits_q[s] = hits_q[s] + 1;
        credit_ep_q[s] = now;
        if (hits_q[s] >= promo_thresh) cls_q[s] = CLS_PROMO;
        r.status = ST_DONE;
      end
      r.frequency_class = cls_q[s];
      r.score_now = sc;
      r.hits_now = hits_q[s];
      return r;
    end
    // quote: prior decays with age since admission
    steps = (now - adm_q[s]) / decay_ivl;
    raw = (64'd65536 * prior_q[s]) / 64'd1000;
    pq = (steps >= 64) ? 64'd0 : (raw >> steps);
    sig = {32'd0, sc} + pq;
    if (it.avoided_work != 0 && sig > 64'hFFFF_FFFF_FFFF_FFFF / it.avoided_work)
      return reject_result();
    r.status = ST_DONE;
    r.frequency_class = cls_q[s];
    r.score_now = sc;
    r.hits_now = hits_q[s];
    r.lost_value = sig * it.avoided_work;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    dft_out_t exp_r;
    if (rst_n && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", result);
      end else begin
        exp_r = pending_results.pop_front();
        if (result.status !== exp_r.status ||
            result.frequency_class !== exp_r.frequency_class ||
            result.score_now !== exp_r.score_now ||
            result.hits_now !== exp_r.hits_now ||
            result.lost_value !== exp_r.lost_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch exp %p got %p", exp_r, result);
        end
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one item; returns after it was accepted
  task automatic send_item(dft_in_t it);
    dft_out_t exp_r;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    exp_r = track_item(it);
    pending_results = {pending_results, exp_r};
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Write all four registers while idle
  task automatic set_config(logic [31:0] ca, logic [31:0] sm, logic [31:0] di,
                            logic [31:0] pt);
    wait_drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= REG_CREDIT; cfg_data <= ca;
    @(negedge clk);
    cfg_idx <= REG_SMAX; cfg_data <= sm;
    @(negedge clk);
    cfg_idx <= REG_DECAY; cfg_data <= di;
    @(negedge clk);
    cfg_idx <= REG_THRESH; cfg_data <= pt;
    @(negedge clk);
    cfg_we <= 1'b0;
    credit_amt = ca; score_max = sm; decay_ivl = di; promo_thresh = pt;
  endtask

  function automatic dft_in_t mk(logic [1:0] a, logic [7:0] s, logic [31:0] e,
                                 logic [9:0] p, logic u, logic [31:0] av,
                                 logic [31:0] c, logic [31:0] rk);
    dft_in_t it;
    it.action = a; it.slot = s; it.epoch = e; it.prior_permille = p;
    it.start_unavailable = u; it.avoided_work = av; it.marginal_cost = c;
    it.recency_rank = rk;
    return it;
  endfunction

  // Field extremes, each action and the reject/unavailable/coalesce cases
  task automatic test_directed();
    idle_pct = 0;
    send_item(mk(ACT_CREDIT, 8'd7, 32'd5, 10'd0, 1'b0, 32'd1, 32'd1, 32'd1));
    send_item(mk(ACT_QUOTE, 8'd7, 32'd5, 10'd0, 1'b0, 32'd1, 32'd1, 32'd1));
    send_item(mk(ACT_ADMIT, 8'd0, 32'd1, 10'd1000, 1'b0, '0, '0, '0));
    send_item(mk(ACT_ADMIT, 8'd255, 32'hFFFF_FFFF, 10'd1, 1'b1, '1, '1, '1));
    send_item(mk(ACT_ADMIT, 8'd1, 32'd0, 10'd500, 1'b0, '0, '0, '0));
    send_item(mk(ACT_ADMIT, 8'd1, 32'd9, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_ADMIT, 8'd1, 32'd9, 10'd1023, 1'b0, '0, '0, '0));
    send_item(mk(ACT_ADMIT, 8'd1, 32'd9, 10'd1001, 1'b0, '0, '0, '0));
    send_item(mk(ACT_RESERVED, 8'd0, 32'd1, 10'd5, 1'b0, '1, '1, '1));
    send_item(mk(ACT_CREDIT, 8'd0, 32'd1, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_CREDIT, 8'd0, 32'd1, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_CREDIT, 8'd0, 32'd3, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_QUOTE, 8'd0, 32'd4, 10'd0, 1'b0, '1, 32'd3, 32'd2));
    send_item(mk(ACT_QUOTE, 8'd0, 32'd4, 10'd0, 1'b0, '1, 32'd0, 32'd2));
    send_item(mk(ACT_QUOTE, 8'd0, 32'd4, 10'd0, 1'b0, '1, 32'd3, 32'd0));
    send_item(mk(ACT_QUOTE, 8'd0, 32'd4, 10'd0, 1'b0, '0, '1, '1));
    send_item(mk(ACT_CREDIT, 8'd0, 32'd0, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_QUOTE, 8'd0, 32'd200, 10'd0, 1'b0, 32'd7, '1, '1));
    send_item(mk(ACT_CREDIT, 8'd255, 32'hFFFF_FFFF, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_QUOTE, 8'd255, 32'hFFFF_FFFF, 10'd0, 1'b0, '1, '1, '1));
  endtask

  // Saturating score, quote overflow and each invalid register setting
  task automatic test_config_limits();
    set_config(32'hF000_0000, 32'hFFFF_FFFF, 32'd1, 32'd2);
    send_item(mk(ACT_ADMIT, 8'd2, 32'd10, 10'd1000, 1'b0, '0, '0, '0));
    send_item(mk(ACT_CREDIT, 8'd2, 32'd10, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_CREDIT, 8'd2, 32'd11, 10'd0, 1'b0, '0, '0, '0));
    send_item(mk(ACT_QUOTE, 8'd2, 32'd11, 10'd0, 1'b0, '1, '1, '1));
    send_item(mk(ACT_QUOTE, 8'd2, 32'd11, 10'd0, 1'b0, 32'd3, '1, '1));
    set_config(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2);
    send_item(mk(ACT_CREDIT, 8'd2, 32'd12, 10'd0, 1'b0, '0, '0, '0));
    set_config(32'd10, 32'd9, 32'd1, 32'd2);
    send_item(mk(ACT_QUOTE, 8'd2, 32'd12, 10'd0, 1'b0, 32'd1, '1, '1));
    set_config(32'd10, 32'd10, 32'd0, 32'd2);
    send_item(mk(ACT_CREDIT, 8'd2, 32'd12, 10'd0, 1'b0, '0, '0, '0));
    set_config(32'd10, 32'd10, 32'd1, 32'd1);
    send_item(mk(ACT_CREDIT, 8'd2, 32'd12, 10'd0, 1'b0, '0, '0, '0));
  endtask

  function automatic dft_in_t rand_item();
    dft_in_t     it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.action = (pick < 20) ? ACT_ADMIT : (pick < 63) ? ACT_CREDIT :
                (pick < 95) ? ACT_QUOTE : ACT_RESERVED;
    it.slot = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 35) ;
    else if (pick < 85) epoch_now = epoch_now + $urandom_range(1, 4);
    else if (pick < 95) epoch_now = epoch_now + $urandom_range(5, 2000);
    it.epoch = ($urandom_range(99) < 4) ? $urandom() : epoch_now;
    pick = $urandom_range(99);
    it.prior_permille = (pick < 4) ? 10'd0 : (pick < 8) ? 10'($urandom_range(1001, 1023)) :
                        10'($urandom_range(1, 1000));
    it.start_unavailable = ($urandom_range(99) < 15);
    pick = $urandom_range(99);
    it.avoided_work = (pick < 10) ? 32'd0 : (pick < 55) ? $urandom() : $urandom_range(1, 5000);
    it.marginal_cost = ($urandom_range(99) < 5) ? 32'd0 : $urandom();
    it.recency_rank = ($urandom_range(99) < 5) ? 32'd0 : $urandom();
    return it;
  endfunction

  task automatic test_random_phase(int unsigned n_items, int unsigned idle);
    idle_pct = idle;
    epoch_now = ($urandom_range(1) == 1) ? $urandom_range(1, 100) :
                $urandom_range(32'h0000_1000, 32'hFFF0_0000);
    for (int unsigned i = 0; i < n_items; i++) begin
      send_item(rand_item());
      // hold off until the block has drained
      if ($urandom_range(99) == 0) wait_drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_CREDIT;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    idle_pct = 0;
    epoch_now = 32'd1;
    credit_amt = 32'd65536; score_max = 32'hFFFF_FFFF; decay_ivl = 32'd1; promo_thresh = 32'd2;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      used_q[i] = 1'b0; cls_q[i] = '0; score_q[i] = '0; hits_q[i] = '0;
      adm_q[i] = '0; cursor_q[i] = '0; credit_ep_q[i] = '0; prior_q[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_limits();
    set_config(32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd2);
    test_random_phase(260, 0);
    set_config(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
    test_random_phase(260, 69);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    test_random_phase(260, 32);
    set_config(32'd1000, 32'd50000, 32'd3, 32'd5);
    test_random_phase(260, 0);
    set_config($urandom_range(1, 32'h0010_0000), $urandom_range(32'h0010_0000, 32'hFFFF_FFFF),
               $urandom_range(1, 7), $urandom_range(2, 9));
    test_random_phase(260, 69);

    wait_drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
